@@ rtl/wsb_pkg.sv @@
// wsb_pkg: shared widths, register codes, types and state encodings of the speed balancer
`timescale 1ns / 1ps
package wsb_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int DRIVE_WIDTH = 8;
    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 32;
    localparam int WIN_W       = 16;
    localparam int TOL_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // counts per second from counts per millisecond
    localparam int SCALE   = 1000;
    localparam int SCALE_W = 10;
    localparam int DELTA_W = COUNT_WIDTH + 1;
    localparam int PROD_W  = DELTA_W + SCALE_W;
    localparam int DCNT_W  = $clog2(PROD_W);

    localparam logic [PROD_W-1:0] SAT_NEG_Q = PROD_W'(1) << (SPEED_W - 1);
    localparam logic [PROD_W-1:0] SAT_POS_Q = SAT_NEG_Q - PROD_W'(1);

    localparam int IN_W        = TIME_W + 2 * COUNT_WIDTH + 2 * DRIVE_WIDTH;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 2 * DRIVE_WIDTH + 2 * SPEED_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [WIN_W-1:0]       WINDOW_RESET = WIN_W'(50);
    localparam logic [TOL_W-1:0]       TOL_RESET    = TOL_W'(10);
    localparam logic [DRIVE_WIDTH-1:0] STEP_RESET   = DRIVE_WIDTH'(1);
    localparam logic [DRIVE_WIDTH-1:0] MIN_RESET    = '0;
    localparam logic [DRIVE_WIDTH-1:0] MAX_RESET    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 3'd0,
        CFG_TOL    = 3'd1,
        CFG_STEP   = 3'd2,
        CFG_MIN    = 3'd3,
        CFG_MAX    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [WIN_W-1:0]       window_ms;
        logic [TOL_W-1:0]       speed_tolerance;
        logic [DRIVE_WIDTH-1:0] drive_step;
        logic [DRIVE_WIDTH-1:0] min_drive;
        logic [DRIVE_WIDTH-1:0] max_drive;
    } cfg_t;

    typedef struct packed {
        logic               done;
        logic [SPEED_W-1:0] speed;
    } lane_res_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIV,
        LN_FIN
    } lane_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_DIV,
        TOP_OUT
    } top_state_t;

endpackage

@@ rtl/two_wheel_speed_balancer_top.sv @@
// two_wheel_speed_balancer_top: control call sequencing, windowing state and result register
//
// Each s_ transaction is one control call: a millisecond time, the right and left
// encoder counts and the two current drive values. Each call gives exactly one
// m_ transaction with both adjusted drives and the held wheel speeds; m_tuser is
// set when the call opened a new window and recomputed the speeds.
// Registers are written on the cfg_ channel (index 0 window_ms, 1 speed_tolerance,
// 2 drive_step, 3 min_drive, 4 max_drive); other indexes are ignored. cfg_ready is
// always high; write only while no call is in flight.
// A call that recomputes the speeds passes through the two lanes' bit-serial
// dividers (a multiply step, then 43 quotient bits); the sequencer then takes
// the speeds and loads the result. A call inside the window goes straight to
// the result load. One call is in flight at a time and s_tready is high only
// when the sequencer is idle, so the next call is taken only after the previous
// one has loaded its result.
// The result sits in an output register, so the next call is taken while the
// previous result is still waiting; if the receiver stalls, the finished call
// waits in the sequencer until the register frees up.
// Reset clears all window state and speeds to zero and loads the register
// defaults (50, 10, 1, 0, 255).
`timescale 1ns / 1ps
module two_wheel_speed_balancer_top
    import wsb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // time_ms, right_count, left_count, drive_a_in, drive_b_in (from bit 0 up)
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // drive_a, drive_b, right_speed, left_speed (from bit 0 up)
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // speeds_updated
    output logic                   m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    top_state_t state_reg, state_next;

    cfg_t                   cfg_reg;
    logic [TIME_W-1:0]      last_time_reg;
    logic [COUNT_WIDTH-1:0] prev_right_reg;
    logic [COUNT_WIDTH-1:0] prev_left_reg;
    logic [SPEED_W-1:0]     right_speed_reg;
    logic [SPEED_W-1:0]     left_speed_reg;
    logic [DRIVE_WIDTH-1:0] drive_a_hold_reg;
    logic [DRIVE_WIDTH-1:0] drive_b_hold_reg;
    logic                   upd_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;
    logic                   m_tvalid_reg;

    logic [TIME_W-1:0]      in_time;
    logic [COUNT_WIDTH-1:0] in_right;
    logic [COUNT_WIDTH-1:0] in_left;
    logic [DRIVE_WIDTH-1:0] in_da;
    logic [DRIVE_WIDTH-1:0] in_db;
    logic [TIME_W-1:0]      elapsed;
    logic [WIN_W-1:0]       win;
    logic                   in_window_done;
    logic                   s_fire;
    logic                   lane_start;
    logic                   out_load;
    lane_res_t              right_res;
    lane_res_t              left_res;
    logic [DRIVE_WIDTH-1:0] drive_a;
    logic [DRIVE_WIDTH-1:0] drive_b;

    assign in_time  = s_tdata[TIME_W-1:0];
    assign in_right = s_tdata[TIME_W +: COUNT_WIDTH];
    assign in_left  = s_tdata[TIME_W + COUNT_WIDTH +: COUNT_WIDTH];
    assign in_da    = s_tdata[TIME_W + 2 * COUNT_WIDTH +: DRIVE_WIDTH];
    assign in_db    = s_tdata[TIME_W + 2 * COUNT_WIDTH + DRIVE_WIDTH +: DRIVE_WIDTH];

    // a zero window acts as one so the divisor is never zero
    assign win            = (cfg_reg.window_ms == '0) ? WIN_W'(1) : cfg_reg.window_ms;
    assign elapsed        = in_time - last_time_reg;
    assign in_window_done = (elapsed >= TIME_W'(win));
    assign s_fire         = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tvalid  = m_tvalid_reg;

    wsb_lane u_lane_right (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (lane_start),
        .cur_count  (in_right),
        .prev_count (prev_right_reg),
        .divisor    (elapsed),
        .res        (right_res)
    );

    wsb_lane u_lane_left (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (lane_start),
        .cur_count  (in_left),
        .prev_count (prev_left_reg),
        .divisor    (elapsed),
        .res        (left_res)
    );

    wsb_merge u_merge (
        .cfg         (cfg_reg),
        .right_speed (right_speed_reg),
        .left_speed  (left_speed_reg),
        .drive_a_in  (drive_a_hold_reg),
        .drive_b_in  (drive_b_hold_reg),
        .drive_a     (drive_a),
        .drive_b     (drive_b)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_IDLE: begin
                if (s_tvalid) begin
                    state_next = in_window_done ? TOP_DIV : TOP_OUT;
                end
            end
            TOP_DIV: begin
                if (right_res.done && left_res.done) begin
                    state_next = TOP_OUT;
                end
            end
            TOP_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = TOP_IDLE;
                end
            end
            default: state_next = TOP_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == TOP_IDLE);
        lane_start = (state_reg == TOP_IDLE) && s_tvalid && in_window_done;
        out_load   = (state_reg == TOP_OUT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= TOP_IDLE;
            cfg_reg         <= '{WINDOW_RESET, TOL_RESET, STEP_RESET, MIN_RESET, MAX_RESET};
            last_time_reg   <= '0;
            prev_right_reg  <= '0;
            prev_left_reg   <= '0;
            right_speed_reg <= '0;
            left_speed_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_WINDOW: cfg_reg.window_ms       <= cfg_data[WIN_W-1:0];
                    CFG_TOL:    cfg_reg.speed_tolerance <= cfg_data[TOL_W-1:0];
                    CFG_STEP:   cfg_reg.drive_step      <= cfg_data[DRIVE_WIDTH-1:0];
                    CFG_MIN:    cfg_reg.min_drive       <= cfg_data[DRIVE_WIDTH-1:0];
                    CFG_MAX:    cfg_reg.max_drive       <= cfg_data[DRIVE_WIDTH-1:0];
                    default: ;
                endcase
            end
            // lanes capture the old counts in the same cycle
            if (lane_start) begin
                last_time_reg  <= in_time;
                prev_right_reg <= in_right;
                prev_left_reg  <= in_left;
            end
            if (state_reg == TOP_DIV && right_res.done && left_res.done) begin
                right_speed_reg <= right_res.speed;
                left_speed_reg  <= left_res.speed;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            drive_a_hold_reg <= in_da;
            drive_b_hold_reg <= in_db;
            upd_reg          <= in_window_done;
        end
        if (out_load) begin
            m_tdata_reg <= OUT_TDATA_W'({left_speed_reg, right_speed_reg, drive_b, drive_a});
            m_tuser_reg <= upd_reg;
        end
    end

endmodule

@@ rtl/wsb_lane.sv @@
// wsb_lane: one wheel's speed unit, count delta times scale then a bit-serial divide
`timescale 1ns / 1ps
module wsb_lane
    import wsb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] cur_count,
    input  logic [COUNT_WIDTH-1:0] prev_count,
    input  logic [TIME_W-1:0]      divisor,
    output lane_res_t              res
);

    lane_state_t state_reg, state_next;

    logic [DELTA_W-1:0] mag_reg;
    logic               neg_reg;
    logic [TIME_W-1:0]  div_reg;
    logic [PROD_W-1:0]  dvd_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic [DCNT_W-1:0]  cnt_reg;

    logic [DELTA_W-1:0] delta;
    logic [TIME_W:0]    trial;
    logic               qbit;
    logic [TIME_W:0]    trial_sub;

    assign delta = {cur_count[COUNT_WIDTH-1], cur_count}
                 - {prev_count[COUNT_WIDTH-1], prev_count};

    // restoring divide step: remainder stays below the divisor
    assign trial     = {rem_reg, dvd_reg[PROD_W-1]};
    assign qbit      = (trial >= {1'b0, div_reg});
    assign trial_sub = trial - {1'b0, div_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE: begin
                if (start) begin
                    state_next = LN_MUL;
                end
            end
            LN_MUL: state_next = LN_DIV;
            LN_DIV: begin
                if (cnt_reg == DCNT_W'(PROD_W - 1)) begin
                    state_next = LN_FIN;
                end
            end
            LN_FIN: state_next = LN_IDLE;
            default: state_next = LN_IDLE;
        endcase
    end

    always_comb begin
        res.done  = (state_reg == LN_FIN);
        res.speed = dvd_reg[SPEED_W-1:0];
        if (neg_reg) begin
            if (dvd_reg >= SAT_NEG_Q) begin
                res.speed = SAT_NEG_Q[SPEED_W-1:0];
            end else begin
                res.speed = -dvd_reg[SPEED_W-1:0];
            end
        end else if (dvd_reg > SAT_POS_Q) begin
            res.speed = SAT_POS_Q[SPEED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == LN_IDLE && start) begin
            neg_reg <= delta[DELTA_W-1];
            mag_reg <= delta[DELTA_W-1] ? -delta : delta;
            div_reg <= divisor;
        end
        if (state_reg == LN_MUL) begin
            dvd_reg <= PROD_W'(mag_reg) * PROD_W'(SCALE);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (state_reg == LN_DIV) begin
            rem_reg <= qbit ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
            dvd_reg <= {dvd_reg[PROD_W-2:0], qbit};
            cnt_reg <= cnt_reg + DCNT_W'(1);
        end
    end

endmodule

@@ rtl/wsb_merge.sv @@
// wsb_merge: compares the two lane speeds and steps and clamps the drives
`timescale 1ns / 1ps
module wsb_merge
    import wsb_pkg::*;
(
    input  cfg_t                   cfg,
    input  logic [SPEED_W-1:0]     right_speed,
    input  logic [SPEED_W-1:0]     left_speed,
    input  logic [DRIVE_WIDTH-1:0] drive_a_in,
    input  logic [DRIVE_WIDTH-1:0] drive_b_in,
    output logic [DRIVE_WIDTH-1:0] drive_a,
    output logic [DRIVE_WIDTH-1:0] drive_b
);

    localparam int DV_W = DRIVE_WIDTH + 2;

    logic signed [SPEED_W:0]   diff;
    logic        [SPEED_W:0]   abs_diff;
    logic                      boost;
    logic                      left_faster;
    logic signed [DV_W-1:0]    da;
    logic signed [DV_W-1:0]    db;
    logic signed [DV_W-1:0]    stp;

    function automatic logic [DRIVE_WIDTH-1:0] clamp(
        input logic signed [DV_W-1:0]  v,
        input logic [DRIVE_WIDTH-1:0]  lo,
        input logic [DRIVE_WIDTH-1:0]  hi
    );
        logic signed [DV_W-1:0] lo_s;
        logic signed [DV_W-1:0] hi_s;
        logic [DRIVE_WIDTH-1:0] r;
        lo_s = $signed({2'b00, lo});
        hi_s = $signed({2'b00, hi});
        priority if (v > hi_s) begin
            r = hi;
        end else if (v < lo_s) begin
            r = lo;
        end else begin
            r = v[DRIVE_WIDTH-1:0];
        end
        return r;
    endfunction

    always_comb begin
        diff = $signed({left_speed[SPEED_W-1], left_speed})
             - $signed({right_speed[SPEED_W-1], right_speed});
        abs_diff    = diff[SPEED_W] ? -diff : diff;
        boost       = (abs_diff >= (SPEED_W + 1)'(cfg.speed_tolerance));
        left_faster = ($signed(left_speed) > $signed(right_speed));
        stp = $signed({2'b00, cfg.drive_step});
        da  = $signed({2'b00, drive_a_in});
        db  = $signed({2'b00, drive_b_in});
        // boost the slower wheel, otherwise trim the faster one
        if (boost) begin
            if (left_faster) begin
                db = db + stp;
            end else begin
                da = da + stp;
            end
        end else begin
            if (left_faster) begin
                da = da - stp;
            end else begin
                db = db - stp;
            end
        end
        drive_a = clamp(da, cfg.min_drive, cfg.max_drive);
        drive_b = clamp(db, cfg.min_drive, cfg.max_drive);
    end

endmodule
